// File: src/sva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared codes, field widths, the result record and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sva_pkg;

    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int CMD_W      = 3;
    localparam int ACT_W      = 3;
    localparam int MODE_W     = 2;
    localparam int MAXV_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int HALF_W     = 64;
    localparam int MASK_W     = 128;

    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEDAL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SILENT   = 3'd4;

    localparam logic [ACT_W-1:0] ACT_TRIGGER   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STEAL     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GLIDE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET_ALL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MASK      = 3'd5;

    localparam logic [MODE_W-1:0] MODE_POLY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEGATO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOICES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KB_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTA_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_NOTE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_NOTE  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_APPLY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NOTE_W-1:0] voice;
        logic [NOTE_W-1:0] target;
        logic [NOTE_W-1:0] gfrom;
        logic              gvalid;
        logic              porta;
        logic              hard;
        logic [VEL_W-1:0]  vel;
        logic [MASK_W-1:0] mask;
        logic              last;
    } t_result;

endpackage

// File: src/sva_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/synth_voice_allocator.sv
// ----------------------------------------------------------------------------
// Flow: each item makes one pass over the stamp RAM through its single read
// port, then its results are presented one at a time, held under i_out_stall.
// Throughput: one item at a time; the next is taken once all results are out.
// Reset: synchronous, clears state, settings, key flags and stamp counter; not the stamp RAM or scan registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module synth_voice_allocator #(
    parameter int NUM_KEYS   = 128,
    parameter int STAMP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sva_pkg::CMD_W-1:0]           i_command,
    input  logic [sva_pkg::NOTE_W-1:0]          i_note,
    input  logic [sva_pkg::VEL_W-1:0]           i_velocity,
    input  logic                                i_key_mapped,
    input  logic [sva_pkg::VEL_W-1:0]           i_pedal_value,
    input  logic                                i_cfg_we,
    input  logic [sva_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sva_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sva_pkg::ACT_W-1:0]           o_action,
    output logic [sva_pkg::NOTE_W-1:0]          o_voice,
    output logic [sva_pkg::NOTE_W-1:0]          o_target_note,
    output logic [sva_pkg::NOTE_W-1:0]          o_glide_from_note,
    output logic                                o_glide_from_valid,
    output logic                                o_portamento_on,
    output logic                                o_hard_restart,
    output logic [sva_pkg::VEL_W-1:0]           o_out_velocity,
    output logic [sva_pkg::HALF_W-1:0]          o_release_mask_low,
    output logic [sva_pkg::HALF_W-1:0]          o_release_mask_high,
    output logic                                o_last
);

    import sva_pkg::*;

    localparam int KEY_W = $clog2(NUM_KEYS);
    localparam int CNT_W = $clog2(NUM_KEYS + 1);
    localparam logic [NOTE_W:0]    NK_LIM   = (NOTE_W + 1)'(NUM_KEYS);
    localparam logic [KEY_W-1:0]   LAST_KEY = KEY_W'(NUM_KEYS - 1);

    t_state r_state, n_state;

    logic [MAXV_W-1:0]     r_maxv, n_maxv;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic                  r_pmode, n_pmode;
    logic [NOTE_W-1:0]     r_lo, n_lo;
    logic [NOTE_W-1:0]     r_hi, n_hi;

    logic [NUM_KEYS-1:0]   r_held, n_held;
    logic [NUM_KEYS-1:0]   r_active, n_active;
    logic [NUM_KEYS-1:0]   r_svld, n_svld;
    logic [STAMP_BITS-1:0] r_stamp, n_stamp;
    logic                  r_sustain, n_sustain;
    logic [NOTE_W-1:0]     r_prev, n_prev;
    logic                  r_prev_vld, n_prev_vld;

    logic [CMD_W-1:0]      r_cmd;
    logic [NOTE_W-1:0]     r_note;
    logic [VEL_W-1:0]      r_vel;
    logic                  r_mapped;
    logic [VEL_W-1:0]      r_pedal;

    logic [KEY_W-1:0]      r_addr, n_addr;
    logic                  r_pvld;
    logic [KEY_W-1:0]      r_pidx;

    logic                  r_any_held, n_any_held;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_na_fnd, n_na_fnd;
    logic [STAMP_BITS-1:0] r_na_best, n_na_best;
    logic [KEY_W-1:0]      r_na_idx, n_na_idx;
    logic                  r_nh_fnd, n_nh_fnd;
    logic [STAMP_BITS-1:0] r_nh_best, n_nh_best;
    logic [KEY_W-1:0]      r_nh_idx, n_nh_idx;
    logic                  r_or_fnd, n_or_fnd;
    logic [STAMP_BITS-1:0] r_or_best, n_or_best;
    logic [KEY_W-1:0]      r_or_idx, n_or_idx;
    logic                  r_oa_fnd, n_oa_fnd;
    logic [STAMP_BITS-1:0] r_oa_best, n_oa_best;
    logic [KEY_W-1:0]      r_oa_idx, n_oa_idx;
    logic [NUM_KEYS-1:0]   r_mask, n_mask;
    logic                  r_any_cand, n_any_cand;

    t_result               r_res0, n_res0;
    t_result               r_res1, n_res1;
    logic [1:0]            r_nres, n_nres;
    logic                  r_oidx, n_oidx;

    logic                  in_acc;
    logic                  out_acc;
    logic [NUM_KEYS-1:0]   rng;
    logic                  ram_we;
    logic [STAMP_BITS-1:0] ram_wdata;
    logic [STAMP_BITS-1:0] ram_rdata;
    t_result               cur;

    sva_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (NUM_KEYS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_note[KEY_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        for (int j = 0; j < NUM_KEYS; j++) begin
            rng[j] = (NOTE_W'(j) >= r_lo) && (NOTE_W'(j) <= r_hi);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_KEY) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: n_state = ST_APPLY;
            ST_APPLY: begin
                n_state = (n_nres != 2'd0) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_acc && cur.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall  = 1'b0;
            ST_OUT:   o_out_valid = 1'b1;
            default: begin
                o_in_stall  = 1'b1;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign cur                 = r_oidx ? r_res1 : r_res0;
    assign o_action            = cur.action;
    assign o_voice             = cur.voice;
    assign o_target_note       = cur.target;
    assign o_glide_from_note   = cur.gfrom;
    assign o_glide_from_valid  = cur.gvalid;
    assign o_portamento_on     = cur.porta;
    assign o_hard_restart      = cur.hard;
    assign o_out_velocity      = cur.vel;
    assign o_release_mask_low  = cur.mask[HALF_W-1:0];
    assign o_release_mask_high = cur.mask[MASK_W-1:HALF_W];
    assign o_last              = cur.last;

    // Scan accumulators: one stamp per cycle from the RAM.
    always_comb begin
        logic [STAMP_BITS-1:0] eff;
        logic                  hj;
        logic                  aj;
        logic                  isn;
        logic                  hx;
        logic                  hrel;
        eff  = r_svld[r_pidx] ? ram_rdata : '0;
        hj   = r_held[r_pidx];
        aj   = r_active[r_pidx];
        isn  = (r_pidx == r_note[KEY_W-1:0]);
        hx   = hj && !((r_cmd == CMD_NOTE_OFF) && isn);
        hrel = hj || ((r_cmd == CMD_NOTE_ON) && isn);

        n_addr     = r_addr;
        n_any_held = r_any_held;
        n_cnt      = r_cnt;
        n_na_fnd   = r_na_fnd;
        n_na_best  = r_na_best;
        n_na_idx   = r_na_idx;
        n_nh_fnd   = r_nh_fnd;
        n_nh_best  = r_nh_best;
        n_nh_idx   = r_nh_idx;
        n_or_fnd   = r_or_fnd;
        n_or_best  = r_or_best;
        n_or_idx   = r_or_idx;
        n_oa_fnd   = r_oa_fnd;
        n_oa_best  = r_oa_best;
        n_oa_idx   = r_oa_idx;
        n_mask     = r_mask;
        n_any_cand = r_any_cand;

        if (r_state == ST_IDLE) begin
            n_addr     = '0;
            n_any_held = 1'b0;
            n_cnt      = '0;
            n_na_fnd   = 1'b0;
            n_na_best  = '0;
            n_nh_fnd   = 1'b0;
            n_nh_best  = '0;
            n_or_fnd   = 1'b0;
            n_oa_fnd   = 1'b0;
            n_mask     = '0;
            n_any_cand = 1'b0;
        end else if (r_state == ST_SCAN) begin
            n_addr = r_addr + 1'b1;
        end

        if (r_pvld) begin
            n_any_held = r_any_held || hj;
            n_cnt      = r_cnt + CNT_W'(aj);
            if (eff > r_na_best) begin
                n_na_fnd  = 1'b1;
                n_na_best = eff;
                n_na_idx  = r_pidx;
            end
            if (hx && (eff > r_nh_best)) begin
                n_nh_fnd  = 1'b1;
                n_nh_best = eff;
                n_nh_idx  = r_pidx;
            end
            if (aj && !hrel && (!r_or_fnd || (eff < r_or_best))) begin
                n_or_fnd  = 1'b1;
                n_or_best = eff;
                n_or_idx  = r_pidx;
            end
            if (aj && (!r_oa_fnd || (eff < r_oa_best))) begin
                n_oa_fnd  = 1'b1;
                n_oa_best = eff;
                n_oa_idx  = r_pidx;
            end
            if (!hj && (eff != '0) && rng[r_pidx]) begin
                n_mask[r_pidx] = 1'b1;
                n_any_cand     = 1'b1;
            end
        end
    end

    // Item outcome and configuration writes.
    always_comb begin
        t_result          res;
        logic             nin;
        logic [KEY_W-1:0] nk;
        logic             porta_ok;
        logic             mono;
        logic [KEY_W-1:0] v;
        logic             v_ok;
        logic [STAMP_BITS-1:0] ns;

        n_maxv     = r_maxv;
        n_mode     = r_mode;
        n_pmode    = r_pmode;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_held     = r_held;
        n_active   = r_active;
        n_svld     = r_svld;
        n_stamp    = r_stamp;
        n_sustain  = r_sustain;
        n_prev     = r_prev;
        n_prev_vld = r_prev_vld;
        n_res0     = r_res0;
        n_res1     = r_res1;
        n_nres     = r_nres;
        n_oidx     = r_oidx;
        ram_we     = 1'b0;

        nin      = ({1'b0, r_note} < NK_LIM) && (r_note >= r_lo) && (r_note <= r_hi);
        nk       = r_note[KEY_W-1:0];
        porta_ok = !r_pmode || r_any_held;
        mono     = (r_mode == MODE_MONO) || (r_mode == MODE_LEGATO);
        ns       = r_stamp + 1'b1;
        if (ns == '0) begin
            ns = STAMP_BITS'(1);
        end
        ram_wdata = ns;
        v    = r_or_fnd ? r_or_idx : r_oa_idx;
        v_ok = r_or_fnd || r_oa_fnd;
        res  = '0;

        if (r_state == ST_OUT && out_acc) begin
            n_oidx = 1'b1;
        end

        if (r_state == ST_APPLY) begin
            n_nres = 2'd0;
            n_oidx = 1'b0;
            res.last = 1'b1;
            case (r_cmd)
                CMD_NOTE_ON: begin
                    if (nin && r_mapped) begin
                        n_held[nk] = 1'b1;
                        n_prev     = r_note;
                        n_prev_vld = 1'b1;
                        if (r_mode == MODE_POLY) begin
                            if ((r_maxv != '0) && (MAXV_W'(r_cnt) >= r_maxv) && v_ok) begin
                                n_active[v]  = 1'b0;
                                n_res0       = '0;
                                n_res0.action = ACT_STEAL;
                                n_res0.voice  = NOTE_W'(v);
                                n_nres       = 2'd1;
                            end
                            ram_we       = 1'b1;
                            n_stamp      = ns;
                            n_svld[nk]   = 1'b1;
                            n_active[nk] = 1'b1;
                            res.action   = ACT_TRIGGER;
                            res.voice    = r_note;
                            res.target   = r_note;
                            res.gfrom    = r_prev_vld ? r_prev : '0;
                            res.gvalid   = r_prev_vld;
                            res.porta    = r_prev_vld && porta_ok;
                            res.hard     = 1'b1;
                            res.vel      = r_vel;
                            if (n_nres == 2'd1) begin
                                n_res1 = res;
                                n_nres = 2'd2;
                            end else begin
                                n_res0 = res;
                                n_nres = 2'd1;
                            end
                        end else if (mono) begin
                            ram_we      = 1'b1;
                            n_stamp     = ns;
                            n_svld[nk]  = 1'b1;
                            n_active[0] = 1'b1;
                            res.target  = r_note;
                            res.porta   = porta_ok;
                            res.vel     = r_vel;
                            if ((r_mode == MODE_MONO) || !r_na_fnd) begin
                                res.action = ACT_TRIGGER;
                                res.hard   = !r_active[0];
                            end else begin
                                res.action = ACT_GLIDE;
                            end
                            n_res0 = res;
                            n_nres = 2'd1;
                        end
                    end
                end
                CMD_NOTE_OFF: begin
                    if (nin) begin
                        n_held[nk] = 1'b0;
                        if (!r_sustain) begin
                            if (r_mode == MODE_POLY) begin
                                res.action = ACT_RELEASE;
                                res.voice  = r_note;
                                n_res0     = res;
                                n_nres     = 2'd1;
                            end else if (mono) begin
                                n_svld[nk] = 1'b0;
                                if (!r_nh_fnd) begin
                                    n_stamp = '0;
                                end
                                if (r_na_fnd && (r_na_idx == nk)) begin
                                    if (r_nh_fnd) begin
                                        res.action = (r_mode == MODE_MONO) ? ACT_TRIGGER
                                                                           : ACT_GLIDE;
                                        res.target = NOTE_W'(r_nh_idx);
                                        res.porta  = 1'b1;
                                    end else begin
                                        res.action = ACT_RELEASE;
                                    end
                                    n_res0 = res;
                                    n_nres = 2'd1;
                                end
                            end
                        end
                    end
                end
                CMD_PEDAL: begin
                    if (r_pedal != '0) begin
                        n_sustain = 1'b1;
                    end else begin
                        n_sustain  = 1'b0;
                        res.action = ACT_MASK;
                        if (r_mode == MODE_POLY) begin
                            res.mask = MASK_W'(r_mask);
                        end else if (mono) begin
                            n_svld = r_svld & ~(rng & ~r_held);
                            if (r_any_cand && !r_nh_fnd) begin
                                n_stamp = '0;
                            end
                            if (r_na_fnd && rng[r_na_idx] && !r_held[r_na_idx]) begin
                                if (r_nh_fnd) begin
                                    res.action = (r_mode == MODE_MONO) ? ACT_TRIGGER
                                                                       : ACT_GLIDE;
                                    res.target = NOTE_W'(r_nh_idx);
                                    res.porta  = 1'b1;
                                end else begin
                                    res.action = ACT_RELEASE;
                                end
                            end
                        end
                        n_res0 = res;
                        n_nres = 2'd1;
                    end
                end
                CMD_ALL_OFF: begin
                    n_held     = '0;
                    n_active   = '0;
                    n_svld     = '0;
                    n_stamp    = '0;
                    n_sustain  = 1'b0;
                    res.action = ACT_RESET_ALL;
                    n_res0     = res;
                    n_nres     = 2'd1;
                end
                CMD_SILENT: begin
                    if ({1'b0, r_note} < NK_LIM) begin
                        n_active[nk] = 1'b0;
                    end
                end
                default: begin
                    n_nres = 2'd0;
                end
            endcase
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_VOICES: n_maxv  = i_cfg_data;
                CFG_KB_MODE: begin
                    if (i_cfg_data[MODE_W-1:0] != r_mode) begin
                        n_mode    = i_cfg_data[MODE_W-1:0];
                        n_held    = '0;
                        n_active  = '0;
                        n_svld    = '0;
                        n_stamp   = '0;
                        n_sustain = 1'b0;
                    end
                end
                CFG_PORTA_MODE: n_pmode = i_cfg_data[0];
                CFG_LOW_NOTE:   n_lo    = i_cfg_data[NOTE_W-1:0];
                CFG_HIGH_NOTE:  n_hi    = i_cfg_data[NOTE_W-1:0];
                default:        n_maxv  = r_maxv;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_maxv     <= '0;
            r_mode     <= MODE_POLY;
            r_pmode    <= 1'b0;
            r_lo       <= '0;
            r_hi       <= '1;
            r_held     <= '0;
            r_active   <= '0;
            r_svld     <= '0;
            r_stamp    <= '0;
            r_sustain  <= 1'b0;
            r_prev     <= '0;
            r_prev_vld <= 1'b0;
            r_pvld     <= 1'b0;
            r_nres     <= 2'd0;
            r_oidx     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_maxv     <= n_maxv;
            r_mode     <= n_mode;
            r_pmode    <= n_pmode;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_held     <= n_held;
            r_active   <= n_active;
            r_svld     <= n_svld;
            r_stamp    <= n_stamp;
            r_sustain  <= n_sustain;
            r_prev     <= n_prev;
            r_prev_vld <= n_prev_vld;
            r_pvld     <= (r_state == ST_SCAN);
            r_nres     <= n_nres;
            r_oidx     <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_command;
            r_note   <= i_note;
            r_vel    <= i_velocity;
            r_mapped <= i_key_mapped;
            r_pedal  <= i_pedal_value;
        end
        r_pidx     <= r_addr;
        r_addr     <= n_addr;
        r_any_held <= n_any_held;
        r_cnt      <= n_cnt;
        r_na_fnd   <= n_na_fnd;
        r_na_best  <= n_na_best;
        r_na_idx   <= n_na_idx;
        r_nh_fnd   <= n_nh_fnd;
        r_nh_best  <= n_nh_best;
        r_nh_idx   <= n_nh_idx;
        r_or_fnd   <= n_or_fnd;
        r_or_best  <= n_or_best;
        r_or_idx   <= n_or_idx;
        r_oa_fnd   <= n_oa_fnd;
        r_oa_best  <= n_oa_best;
        r_oa_idx   <= n_oa_idx;
        r_mask     <= n_mask;
        r_any_cand <= n_any_cand;
        r_res0     <= n_res0;
        r_res1     <= n_res1;
    end

`ifndef SYNTHESIS
    a_out_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_nres != 2'd0))
        else $error("result phase entered with no result queued");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == ST_IDLE))
        else $error("item not finished after its final result");

    a_stamp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_wdata != '0))
        else $error("zero press stamp written");
`endif

endmodule
